// File: hdl/tisd_pkg.sv
// Shared types and codes for the tagged integer / string decoder.
// No dependencies; imported by tisd_step and tagged_int_string_decoder.
package tisd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_MAG  = 2'd1,
        PH_PAY  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        K_INT = 2'd0,
        K_LEN = 2'd1,
        K_PAY = 2'd2,
        K_ERR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE  = 2'd0,
        E_TYPE  = 2'd1,
        E_TRUNC = 2'd2,
        E_LEN   = 2'd3
    } t_err;

    localparam logic [3:0] SIZE_1B = 4'h1;
    localparam logic [3:0] SIZE_2B = 4'h2;
    localparam logic [3:0] SIZE_4B = 4'h3;
    localparam logic [3:0] SIZE_8B = 4'h4;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bytes_left;
        logic [63:0] acc;
        logic        neg;
        logic        str;
        logic [31:0] pay_left;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [7:0]  pbyte;
        t_err        err;
        logic        last;
    } t_result;

    function automatic t_state idle_state();
        t_state s;
        s.phase      = PH_IDLE;
        s.bytes_left = 4'd0;
        s.acc        = 64'd0;
        s.neg        = 1'b0;
        s.str        = 1'b0;
        s.pay_left   = 32'd0;
        return s;
    endfunction

endpackage

// File: hdl/tisd_step.sv
// Per-byte decode step: next state and optional result for one byte.
// Depends on tisd_pkg.
module tisd_step
    import tisd_pkg::*;
(
    input  t_state      i_state,
    input  logic        i_func,
    input  logic [7:0]  i_byte,
    input  logic        i_eob,
    output t_state      o_state,
    output logic        o_emit,
    output t_result     o_result
);

    logic [63:0] acc_sh;
    logic [3:0]  bl_dec;
    logic [31:0] pl_dec;
    logic [3:0]  size_n;
    logic        size_ok;
    logic        type_byte;

    assign acc_sh = {i_state.acc[55:0], i_byte};
    assign bl_dec = i_state.bytes_left - 4'd1;
    assign pl_dec = i_state.pay_left - 32'd1;

    always_comb begin
        size_ok = 1'b1;
        unique case (i_byte[3:0])
            SIZE_1B: size_n = 4'd1;
            SIZE_2B: size_n = 4'd2;
            SIZE_4B: size_n = 4'd4;
            SIZE_8B: size_n = 4'd8;
            default: begin
                size_n  = 4'd0;
                size_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_state   = i_state;
        o_emit    = 1'b0;
        o_result  = '{kind: K_INT, value: 64'd0, pbyte: 8'd0, err: E_NONE, last: 1'b0};
        type_byte = 1'b0;

        if (i_state.phase == PH_MAG) begin
            o_state.acc        = acc_sh;
            o_state.bytes_left = bl_dec;
            if (bl_dec != 4'd0) begin
                if (i_eob) begin
                    o_emit   = 1'b1;
                    o_result = '{K_ERR, 64'd0, 8'd0, E_TRUNC, 1'b1};
                    o_state  = idle_state();
                end
            end else if (!i_state.str) begin
                o_emit   = 1'b1;
                o_result = '{K_INT, (i_state.neg ? 64'd0 - acc_sh : acc_sh), 8'd0, E_NONE, 1'b1};
                o_state  = idle_state();
            end else if (acc_sh[63:32] != 32'd0 || (i_state.neg && acc_sh != 64'd0)) begin
                o_emit   = 1'b1;
                o_result = '{K_ERR, 64'd0, 8'd0, E_LEN, 1'b1};
                o_state  = idle_state();
            end else if (acc_sh == 64'd0) begin
                o_emit   = 1'b1;
                o_result = '{K_LEN, 64'd0, 8'd0, E_NONE, 1'b1};
                o_state  = idle_state();
            end else if (i_eob) begin
                o_emit   = 1'b1;
                o_result = '{K_ERR, 64'd0, 8'd0, E_TRUNC, 1'b1};
                o_state  = idle_state();
            end else begin
                o_emit           = 1'b1;
                o_result         = '{K_LEN, acc_sh, 8'd0, E_NONE, 1'b0};
                o_state.pay_left = acc_sh[31:0];
                o_state.phase    = PH_PAY;
            end
        end else if (i_state.phase == PH_PAY && i_state.pay_left != 32'd0) begin
            o_emit = 1'b1;
            if (pl_dec != 32'd0 && i_eob) begin
                o_result = '{K_ERR, 64'd0, 8'd0, E_TRUNC, 1'b1};
                o_state  = idle_state();
            end else if (pl_dec == 32'd0) begin
                o_result = '{K_PAY, 64'd0, i_byte, E_NONE, 1'b1};
                o_state  = idle_state();
            end else begin
                o_result         = '{K_PAY, 64'd0, i_byte, E_NONE, 1'b0};
                o_state.pay_left = pl_dec;
            end
        end else begin
            type_byte = 1'b1;
        end

        // Type byte: idle, unused phase code, or an empty payload phase
        if (type_byte) begin
            o_state = idle_state();
            if (!size_ok) begin
                o_emit   = 1'b1;
                o_result = '{K_ERR, 64'd0, 8'd0, E_TYPE, 1'b1};
            end else if (i_eob) begin
                o_emit   = 1'b1;
                o_result = '{K_ERR, 64'd0, 8'd0, E_TRUNC, 1'b1};
            end else begin
                o_state.neg        = (i_byte[7:4] != 4'd0);
                o_state.str        = i_func;
                o_state.bytes_left = size_n;
                o_state.phase      = PH_MAG;
            end
        end
    end

endmodule

// File: hdl/tagged_int_string_decoder.sv
// Top level of the tagged sign-magnitude integer and string decoder.
// Depends on tisd_pkg and tisd_step.
//
// Feed the message one byte per input transaction, with i_func giving the kind
// (0 integer, 1 string) that starts at the next type byte and i_end_of_buffer
// marking the buffer's final byte. A type byte carries the sign in its high
// nibble (nonzero = negative) and a size code 1..4 in its low nibble, selecting
// 1, 2, 4 or 8 big-endian magnitude bytes. An integer gives one result: the
// signed value. A string gives its length and then one result per payload byte,
// with o_last on the final one; an empty string ends on its length. Errors
// (unknown size code, buffer ending early, negative or 2^32+ string length)
// give a single result with o_last set and return the decoder to the type-byte
// state. The block takes one byte per cycle while the output is not stalled: each
// byte is captured in an input register, decoded by a single pass of shift,
// count and compare logic, and any result lands in an output register, so a
// result passes through both registers before it is valid. Bytes that produce no
// result (valid type bytes and magnitude bytes before the last) keep moving even while the output is stalled.
module tagged_int_string_decoder
    import tisd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic signed [63:0] o_decoded_value,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    // Input register
    logic        r_in_valid;
    logic        r_func;
    logic [7:0]  r_byte;
    logic        r_eob;

    // Decoder state and output register
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    t_result     r_result;

    logic        step_emit;
    t_result     step_result;
    logic        out_free;
    logic        advance;
    logic        accept;

    tisd_step u_step (
        .i_state  (r_state),
        .i_func   (r_func),
        .i_byte   (r_byte),
        .i_eob    (r_eob),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    // Output register can take a new result when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    // Retire the held byte unless its result has nowhere to go
    assign advance    = r_in_valid && (!step_emit || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture payload of a new transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_byte <= i_data_byte;
            r_eob  <= i_end_of_buffer;
        end
    end

    // Advance the decode state once per retired byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idle_state();
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result while stalled, load when a new one is produced
    always_ff @(posedge i_clk) begin
        if (advance && step_emit) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_result.kind;
    assign o_decoded_value = r_result.value;
    assign o_payload_byte  = r_result.pbyte;
    assign o_error_code    = r_result.err;
    assign o_last          = r_result.last;

`ifndef SYNTH
    a_mag_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_MAG |-> r_state.bytes_left != 4'd0 && r_state.bytes_left <= 4'd8)
        else $error("magnitude phase with bad byte count");

    a_pay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_PAY |-> r_state.pay_left != 32'd0)
        else $error("payload phase with nothing left");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_IDLE |-> r_state.acc == 64'd0 && r_state.bytes_left == 4'd0)
        else $error("idle state not cleared");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.kind == K_ERR |-> r_result.last && r_result.err != E_NONE)
        else $error("error result without last or code");

    a_no_emit_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step_emit |-> !o_in_stall)
        else $error("byte without result held back");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tagged_int_string_decoder: directed corners, random
// messages, back-to-back traffic and an output hold-off. Depends on tisd_pkg.
module tb;
    import tisd_pkg::*;

    localparam int MAX_GAP      = 19;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_in_valid      = 1'b0;
    logic               o_in_stall;
    logic               i_func          = 1'b0;
    logic [7:0]         i_data_byte     = 8'd0;
    logic               i_end_of_buffer = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall     = 1'b0;
    logic [1:0]         o_kind;
    logic signed [63:0] o_decoded_value;
    logic [7:0]         o_payload_byte;
    logic [1:0]         o_error_code;
    logic               o_last;

    tagged_int_string_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_decoded_value (o_decoded_value),
        .o_payload_byte  (o_payload_byte),
        .o_error_code    (o_error_code),
        .o_last          (o_last)
    );

    // Shadow copy of the decoder state, advanced on every accepted byte.
    t_phase      dec_phase    = PH_IDLE;
    logic [3:0]  dec_left     = 4'd0;
    logic [63:0] dec_mag      = 64'd0;
    logic        dec_neg      = 1'b0;
    logic        dec_str      = 1'b0;
    logic [31:0] dec_pay_left = 32'd0;

    // Decoded tokens still owed by the block, oldest first.
    t_result decoded_queue[$];

    // Idling controls for the sender and the receiver.
    bit in_gaps      = 1'b1;
    bit out_gaps     = 1'b1;
    int hold_request = 0;

    int bytes_sent     = 0;
    int tokens_checked = 0;
    int failures       = 0;
    int kind_seen[4];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: a hung handshake ends the run here.
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_result make_token(t_kind k, logic [63:0] v, logic [7:0] pb,
                                           t_err e, logic l);
        t_result r;
        r.kind  = k;
        r.value = v;
        r.pbyte = pb;
        r.err   = e;
        r.last  = l;
        return r;
    endfunction

    task automatic clear_decoder();
        dec_phase    = PH_IDLE;
        dec_left     = 4'd0;
        dec_mag      = 64'd0;
        dec_neg      = 1'b0;
        dec_str      = 1'b0;
        dec_pay_left = 32'd0;
    endtask

    // Advance the shadow decoder by one byte and queue the token it owes, if any.
    task automatic decode_byte(input logic f, input logic [7:0] b, input logic eob);
        t_result tok;
        bit      emit;
        bit      as_type;
        int      n;
        emit    = 1'b0;
        as_type = 1'b0;
        case (dec_phase)
            PH_MAG: begin
                dec_mag  = {dec_mag[55:0], b};
                dec_left = dec_left - 4'd1;
                emit     = 1'b1;
                if (dec_left != 4'd0) begin
                    // More magnitude to come: only a buffer end says anything.
                    emit = eob;
                    tok  = make_token(K_ERR, 64'd0, 8'd0, E_TRUNC, 1'b1);
                    if (eob) clear_decoder();
                end else if (!dec_str) begin
                    tok = make_token(K_INT, dec_neg ? 64'd0 - dec_mag : dec_mag, 8'd0,
                                     E_NONE, 1'b1);
                    clear_decoder();
                end else if (dec_mag[63:32] != 32'd0 || (dec_neg && dec_mag != 64'd0)) begin
                    tok = make_token(K_ERR, 64'd0, 8'd0, E_LEN, 1'b1);
                    clear_decoder();
                end else if (dec_mag == 64'd0) begin
                    // Empty string (negative zero too) closes on its length.
                    tok = make_token(K_LEN, 64'd0, 8'd0, E_NONE, 1'b1);
                    clear_decoder();
                end else if (eob) begin
                    tok = make_token(K_ERR, 64'd0, 8'd0, E_TRUNC, 1'b1);
                    clear_decoder();
                end else begin
                    tok          = make_token(K_LEN, dec_mag, 8'd0, E_NONE, 1'b0);
                    dec_pay_left = dec_mag[31:0];
                    dec_phase    = PH_PAY;
                    dec_left     = 4'd0;
                end
            end
            PH_PAY: begin
                if (dec_pay_left == 32'd0) begin
                    as_type = 1'b1;
                end else begin
                    dec_pay_left = dec_pay_left - 32'd1;
                    emit         = 1'b1;
                    if (dec_pay_left != 32'd0 && eob) begin
                        // Drop the byte that ends the buffer early.
                        tok = make_token(K_ERR, 64'd0, 8'd0, E_TRUNC, 1'b1);
                        clear_decoder();
                    end else begin
                        tok = make_token(K_PAY, 64'd0, b, E_NONE, dec_pay_left == 32'd0);
                        if (dec_pay_left == 32'd0) clear_decoder();
                    end
                end
            end
            default: as_type = 1'b1;
        endcase
        if (as_type) begin
            clear_decoder();
            case (b[3:0])
                SIZE_1B: n = 1;
                SIZE_2B: n = 2;
                SIZE_4B: n = 4;
                SIZE_8B: n = 8;
                default: n = 0;
            endcase
            // The size code is judged before the buffer end.
            if (n == 0) begin
                emit = 1'b1;
                tok  = make_token(K_ERR, 64'd0, 8'd0, E_TYPE, 1'b1);
            end else if (eob) begin
                emit = 1'b1;
                tok  = make_token(K_ERR, 64'd0, 8'd0, E_TRUNC, 1'b1);
            end else begin
                dec_neg   = |b[7:4];
                dec_str   = f;
                dec_left  = 4'(n);
                dec_mag   = 64'd0;
                dec_phase = PH_MAG;
            end
        end
        if (emit) decoded_queue.push_back(tok);
    endtask

    // Offer one byte, hold it until the block takes it, then predict.
    task automatic send_byte(input logic f, input logic [7:0] b, input logic eob);
        int gap;
        gap = in_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= f;
        i_data_byte     <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        decode_byte(f, b, eob);
        bytes_sent++;
    endtask

    // Send a type byte and its magnitude; eob_at picks the byte that ends the
    // buffer (0 = type byte, -1 = none). Stop once the decoder leaves the
    // magnitude phase.
    task automatic send_value(input logic f, input logic [3:0] sign_nib, input int size_sel,
                              input logic [63:0] mag, input int eob_at);
        logic [3:0] code;
        int         n;
        case (size_sel)
            0:       begin code = SIZE_1B; n = 1; end
            1:       begin code = SIZE_2B; n = 2; end
            2:       begin code = SIZE_4B; n = 4; end
            default: begin code = SIZE_8B; n = 8; end
        endcase
        send_byte(f, {sign_nib, code}, eob_at == 0);
        for (int i = 0; i < n && dec_phase == PH_MAG; i++)
            send_byte(1'($urandom_range(0, 1)), mag[8*(n-1-i) +: 8], eob_at == i + 1);
    endtask

    // Send up to count payload bytes, ending the buffer on the last when cut is set.
    task automatic send_payload(input int count, input bit cut);
        for (int i = 0; i < count && dec_phase == PH_PAY; i++)
            send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      cut && (i == count - 1));
    endtask

    // Magnitudes lean toward the corners; string lengths stay mostly tiny.
    function automatic logic [63:0] pick_magnitude(input logic for_string);
        int sel;
        sel = $urandom_range(0, 9);
        if (for_string) begin
            case (sel)
                0, 1, 2, 3, 4, 5: return 64'($urandom_range(0, 6));
                6:                return {$urandom, $urandom};
                7:                return 64'h0000_0001_0000_0000;
                8:                return '1;
                default:          return 64'h0000_0000_FFFF_FFFF;
            endcase
        end
        case (sel)
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'd1;
            3:       return 64'h8000_0000_0000_0000;
            4:       return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One random message: mostly well formed, some cut short, some noise.
    task automatic send_random_message();
        int          sel;
        int          size_sel;
        int          n;
        int          eob_at;
        int          count;
        bit          cut;
        logic        f;
        logic [3:0]  nib;
        logic [7:0]  b;
        logic [63:0] mag;
        logic [31:0] rem;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 0) b[3:0] = ($urandom_range(0, 1) == 0) ?
                                                    4'h0 : 4'($urandom_range(5, 15));
            send_byte(1'($urandom_range(0, 1)), b, $urandom_range(0, 3) == 0);
            return;
        end
        f        = 1'($urandom_range(0, 1));
        size_sel = $urandom_range(0, 3);
        n        = 1 << size_sel;
        // Strings rarely carry a sign, integers often do.
        if ($urandom_range(0, f ? 4 : 1) == 0)
            nib = 4'($urandom_range(1, 15));
        else
            nib = 4'h0;
        mag    = pick_magnitude(f);
        sel    = $urandom_range(0, 99);
        eob_at = (sel < 12) ? int'($urandom_range(0, n)) : ((sel < 30) ? n : -1);
        send_value(f, nib, size_sel, mag, eob_at);
        if (dec_phase == PH_PAY) begin
            rem = dec_pay_left;
            if (rem > 32'd8) begin
                count = $urandom_range(1, 8);
                cut   = 1'b1;
            end else if (rem > 32'd1 && $urandom_range(0, 4) == 0) begin
                count = $urandom_range(1, int'(rem) - 1);
                cut   = 1'b1;
            end else begin
                count = int'(rem);
                cut   = 1'($urandom_range(0, 1));
            end
            send_payload(count, cut);
        end
    endtask

    // Compare one accepted token against the oldest prediction.
    task automatic check_token();
        t_result want;
        if (decoded_queue.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("unexpected token at %0t: kind %0d value %0h byte %0h err %0d last %0b",
                         $time, o_kind, o_decoded_value, o_payload_byte, o_error_code, o_last);
            return;
        end
        want = decoded_queue.pop_front();
        tokens_checked++;
        kind_seen[want.kind]++;
        if (o_kind !== want.kind || o_decoded_value !== want.value ||
            o_payload_byte !== want.pbyte || o_error_code !== want.err ||
            o_last !== want.last) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("mismatch at %0t: expected kind %0d value %0h byte %0h err %0d last %0b",
                         $time, want.kind, want.value, want.pbyte, want.err, want.last);
                $display("                  got kind %0d value %0h byte %0h err %0d last %0b",
                         o_kind, o_decoded_value, o_payload_byte, o_error_code, o_last);
            end
        end
    endtask

    // Receiver: stall a random number of cycles before each token, plus any
    // long hold-off requested by a test, then take the next token.
    initial begin : sink
        int wait_cycles;
        wait (i_rst_n === 1'b1);
        forever begin
            wait_cycles  = out_gaps ? $urandom_range(0, MAX_GAP) : 0;
            wait_cycles += hold_request;
            hold_request = 0;
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            check_token();
        end
    end

    // Corners: unknown size codes, buffer ends at every stage, signed zero,
    // negative and oversized lengths, empty string, cut-off payload.
    task automatic test_directed_corners();
        send_byte(1'b0, {4'h0, 4'h0}, 1'b0);             // size code zero
        send_byte(1'b1, {4'hF, 4'h5}, 1'b0);             // size code above range
        send_value(1'b0, 4'h0, 0, 64'd0, 0);             // buffer ends on type byte
        send_value(1'b0, 4'h8, 0, 64'h00, 1);            // -0 integer on buffer end
        send_value(1'b0, 4'hF, 0, 64'hFF, -1);           // negative integer
        send_value(1'b1, 4'h0, 1, 64'h0000, 1);          // buffer ends inside magnitude
        send_value(1'b1, 4'h1, 0, 64'd0, -1);            // negative zero length
        send_value(1'b1, 4'h3, 0, 64'd1, -1);            // negative length
        send_value(1'b1, 4'h0, 0, 64'd2, 1);             // length ends the buffer
        send_value(1'b1, 4'h0, 0, 64'd2, -1);            // payload ends on buffer end
        send_byte(1'b0, 8'h00, 1'b0);
        send_byte(1'b1, 8'hFF, 1'b1);
        send_value(1'b1, 4'h0, 0, 64'd3, -1);            // payload cut short
        send_byte(1'b0, 8'hA5, 1'b0);
        send_byte(1'b0, 8'h5A, 1'b1);
    endtask

    task automatic test_random_messages(input int byte_count);
        int stop_at;
        stop_at = bytes_sent + byte_count;
        while (bytes_sent < stop_at) send_random_message();
    endtask

    // Same traffic with neither side idling.
    task automatic test_back_to_back(input int byte_count);
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        test_random_messages(byte_count);
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
    endtask

    // Hold the output off while a long string streams in, so the block backs up
    // and stalls its input.
    task automatic test_output_pressure();
        in_gaps      = 1'b0;
        hold_request = HOLD_CYCLES;
        send_value(1'b1, 4'h0, 0, 64'd60, -1);
        send_payload(60, 1'b0);
        in_gaps = 1'b1;
    endtask

    initial begin : main
        int drain;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_random_messages(400);
        test_back_to_back(80);
        test_output_pressure();

        i_in_valid <= 1'b0;
        // Drain: wait for every owed token, then keep watching for strays.
        drain = 0;
        while (decoded_queue.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (decoded_queue.size() != 0) begin
            failures += decoded_queue.size();
            $display("%0d tokens never arrived", decoded_queue.size());
        end

        $display("Sent %0d bytes; checked %0d integers, %0d lengths, %0d payload bytes, %0d errors",
                 bytes_sent, kind_seen[K_INT], kind_seen[K_LEN], kind_seen[K_PAY],
                 kind_seen[K_ERR]);
        $display("Phases: corner cases, random messages, back-to-back, %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
